// ----- rtl/axis_plane_polygon_clipper_top_macros.svh -----
// Assertion helpers for the polygon clipper top level.
// Both expect clk and arst_n in scope.
`ifndef AXIS_PLANE_POLYGON_CLIPPER_TOP_MACROS_SVH
`define AXIS_PLANE_POLYGON_CLIPPER_TOP_MACROS_SVH

// same-cycle implication
`define APC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define APC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/apc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package apc_pkg;

	localparam int APC_COORD_BITS_DEF = 24;
	localparam int PLANE_BITS         = 24;
	localparam int T_BITS             = 16;
	localparam int CNT_W              = $clog2(T_BITS);
	localparam int CFG_DATA_BITS      = 24;
	localparam int CFG_INDEX_BITS     = 2;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_AXIS   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PLANE_VALUE = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_MODE   = 2'd2;

	// axis selector codes (three acts as z)
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;

	// mode codes (three acts as split)
	localparam logic [1:0] MODE_ABOVE = 2'd0;
	localparam logic [1:0] MODE_BELOW = 2'd1;

	// coordinate slot numbers
	localparam logic [1:0] COORD_X    = 2'd0;
	localparam logic [1:0] COORD_Y    = 2'd1;
	localparam logic [1:0] COORD_LAST = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CROSS_IN,
		ST_DIV,
		ST_MUL,
		ST_ADD,
		ST_PUSH_X,
		ST_KEEP,
		ST_CLOSE,
		ST_FLUSH
	} apc_state_t;

endpackage

`default_nettype wire

// ----- rtl/axis_plane_polygon_clipper_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
//
//  channel   dir  payload                                     end mark / kind
//  s_axis    in   tdata: vertex_x, vertex_y, vertex_z         tlast: is_last_in
//  m_axis    out  tdata: out_x, out_y, out_z                  tlast: is_last_out,
//                                                             tuser: vertex_valid
//  cfg       in   cfg_index selects clip_axis / plane_value / clip_mode, cfg_data
//
//  Sequencing: one request is handled by a sequencer around one shared restoring
//  divider (T_BITS = 16 steps) and one multiplier (3 multiply/add pairs).
//  Each edge crossing runs the divide, the interpolation and a push of the cut
//  vertex; a closing vertex can carry both an incoming and a closing crossing.
//  Reset: arst_n clears the sequencer, the held vertex flag and the cfg registers.
//  Stalls: a full output register holds the sequencer at its next emit; input
//  is taken only in the idle state.
//
module axis_plane_polygon_clipper_top
	import apc_pkg::*;
#(
	parameter int COORD_BITS = APC_COORD_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// slave request: [C-1:0] vertex_x, [2C-1:C] vertex_y, [3C-1:2C] vertex_z
	input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire logic                      s_axis_tlast,
	// master request: [C-1:0] out_x, [2C-1:C] out_y, [3C-1:2C] out_z
	output logic [((3*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	output logic                           m_axis_tlast,
	// master tuser: [0] vertex_valid
	output logic                           m_axis_tuser,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int C         = COORD_BITS;
	localparam int DATA_BITS = ((3*C+7)/8)*8;
	localparam int CW        = (C > PLANE_BITS) ? C : PLANE_BITS;
	localparam int EW        = CW + 1;              // compare / numerator width
	localparam int PW        = C + T_BITS + 2;      // product width

	// configuration
	logic [1:0]                   clip_axis_q;
	logic signed [PLANE_BITS-1:0] plane_value_q;
	logic [1:0]                   clip_mode_q;

	// vertex state
	logic signed [C-1:0] cur_q   [3];
	logic signed [C-1:0] prev_q  [3];
	logic signed [C-1:0] first_q [3];
	logic signed [C-1:0] pend_q  [3];
	logic signed [C-1:0] res_q   [3];
	logic                pend_valid_q;
	logic                started_q;
	logic                last_q;
	logic                phase_q;   // 0 incoming edge, 1 closing edge

	// shared arithmetic
	logic [C-1:0]          rem_q;
	logic [C-1:0]          den_q;
	logic [T_BITS-1:0]     quo_q;
	logic [CNT_W-1:0]      div_cnt_q;
	logic [1:0]            coord_q;
	logic signed [PW-1:0]  prod_q;

	// output register
	logic signed [C-1:0] out_q [3];
	logic                m_tvalid_q;
	logic                m_tlast_q;
	logic                m_tuser_q;

	apc_state_t state_q, state_d;

	// control
	logic accept;
	logic out_free;
	logic push_ok;
	logic push_req;
	logic push_res;
	logic div_load;
	logic edge_close;
	logic flush_done;
	logic flush_emit;
	logic out_load;

	logic [1:0]          ax_idx;
	logic signed [EW-1:0] pl_e;
	logic signed [EW-1:0] cur_ax_e;
	logic signed [EW-1:0] prev_ax_e;
	logic signed [EW-1:0] first_ax_e;
	logic cross_in;
	logic cross_close;
	logic cur_kept;

	logic signed [C-1:0]  p_vec [3];
	logic signed [C-1:0]  q_vec [3];
	logic signed [EW-1:0] num_e;
	logic signed [EW-1:0] den_e;
	logic [EW-1:0]        num_abs;
	logic [EW-1:0]        den_abs;
	logic [C:0]           rem_sh;
	logic [C:0]           rem_sub;
	logic signed [C:0]    dq;
	logic signed [T_BITS:0] t_s;
	logic signed [PW-1:0] prod_d;
	logic signed [C+1:0]  sum_d;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_tvalid_q || m_axis_tready;
	assign push_ok  = !pend_valid_q || out_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_axis_q   <= '0;
			plane_value_q <= '0;
			clip_mode_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLIP_AXIS:   clip_axis_q   <= cfg_data[1:0];
				REG_PLANE_VALUE: plane_value_q <= cfg_data[PLANE_BITS-1:0];
				REG_CLIP_MODE:   clip_mode_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// plane tests on the chosen axis
	always_comb begin
		if (clip_axis_q == AXIS_X) begin
			ax_idx = COORD_X;
		end else if (clip_axis_q == AXIS_Y) begin
			ax_idx = COORD_Y;
		end else begin
			ax_idx = COORD_LAST;
		end
		pl_e       = EW'(plane_value_q);
		cur_ax_e   = EW'(cur_q[ax_idx]);
		prev_ax_e  = EW'(prev_q[ax_idx]);
		first_ax_e = EW'(first_q[ax_idx]);
		cross_in    = (prev_ax_e < pl_e && cur_ax_e > pl_e) ||
		              (prev_ax_e > pl_e && cur_ax_e < pl_e);
		cross_close = (cur_ax_e < pl_e && first_ax_e > pl_e) ||
		              (cur_ax_e > pl_e && first_ax_e < pl_e);
		case (clip_mode_q)
			MODE_ABOVE: cur_kept = (cur_ax_e >= pl_e);
			MODE_BELOW: cur_kept = (cur_ax_e <= pl_e);
			default:    cur_kept = 1'b1;
		endcase
	end

	// edge end points: p -> q
	assign edge_close = (state_q == ST_CLOSE) || ((state_q != ST_CROSS_IN) && phase_q);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			p_vec[k] = edge_close ? cur_q[k]   : prev_q[k];
			q_vec[k] = edge_close ? first_q[k] : cur_q[k];
		end
		num_e   = EW'(p_vec[ax_idx]) - pl_e;
		den_e   = EW'(p_vec[ax_idx]) - EW'(q_vec[ax_idx]);
		num_abs = num_e[EW-1] ? EW'(-num_e) : EW'(num_e);
		den_abs = den_e[EW-1] ? EW'(-den_e) : EW'(den_e);
		rem_sh  = {rem_q, 1'b0};
		rem_sub = rem_sh - {1'b0, den_q};
		dq      = (C+1)'(q_vec[coord_q]) - (C+1)'(p_vec[coord_q]);
		t_s     = {1'b0, quo_q};
		prod_d  = dq * t_s;
		sum_d   = (C+2)'(p_vec[coord_q]) + prod_q[PW-1:T_BITS];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		push_req      = 1'b0;
		push_res      = 1'b0;
		div_load      = 1'b0;
		flush_done    = 1'b0;
		flush_emit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_CROSS_IN;
				end
			end
			ST_CROSS_IN: begin
				if (started_q && cross_in) begin
					div_load = 1'b1;
					state_d  = ST_DIV;
				end else begin
					state_d = ST_KEEP;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == CNT_W'(T_BITS-1)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				state_d = (coord_q == COORD_LAST) ? ST_PUSH_X : ST_MUL;
			end
			ST_PUSH_X: begin
				push_req = 1'b1;
				push_res = 1'b1;
				if (push_ok) begin
					state_d = phase_q ? ST_FLUSH : ST_KEEP;
				end
			end
			ST_KEEP: begin
				if (cur_kept) begin
					push_req = 1'b1;
					if (push_ok) begin
						state_d = ST_CLOSE;
					end
				end else begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				if (last_q && cross_close) begin
					div_load = 1'b1;
					state_d  = ST_DIV;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!last_q || out_free) begin
					flush_done = 1'b1;
					flush_emit = last_q;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// held vertex goes out when a newer one displaces it, or at polygon end
	assign out_load = (push_req && pend_valid_q && out_free) || flush_emit;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			started_q    <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (push_req && push_ok) begin
				pend_valid_q <= 1'b1;
			end else if (flush_done && last_q) begin
				pend_valid_q <= 1'b0;
			end
			if (flush_done) begin
				started_q <= !last_q;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q[0] <= s_axis_tdata[C-1:0];
			cur_q[1] <= s_axis_tdata[2*C-1:C];
			cur_q[2] <= s_axis_tdata[3*C-1:2*C];
			last_q   <= s_axis_tlast;
			if (!started_q) begin
				first_q[0] <= s_axis_tdata[C-1:0];
				first_q[1] <= s_axis_tdata[2*C-1:C];
				first_q[2] <= s_axis_tdata[3*C-1:2*C];
			end
		end
		if (flush_done) begin
			for (int k = 0; k < 3; k++) begin
				prev_q[k] <= cur_q[k];
			end
		end
		if (push_req && push_ok) begin
			for (int k = 0; k < 3; k++) begin
				pend_q[k] <= push_res ? res_q[k] : cur_q[k];
			end
		end
		if (out_load) begin
			for (int k = 0; k < 3; k++) begin
				out_q[k] <= pend_valid_q ? pend_q[k] : '0;
			end
			m_tuser_q <= pend_valid_q;
			m_tlast_q <= flush_emit;
		end
		// restoring divider: t = |num| / |den| in Q0.16
		if (div_load) begin
			rem_q     <= num_abs[C-1:0];
			den_q     <= den_abs[C-1:0];
			quo_q     <= '0;
			div_cnt_q <= '0;
			phase_q   <= (state_q == ST_CLOSE);
			coord_q   <= COORD_X;
		end else if (state_q == ST_DIV) begin
			if (!rem_sub[C]) begin
				rem_q <= rem_sub[C-1:0];
				quo_q <= {quo_q[T_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[C-1:0];
				quo_q <= {quo_q[T_BITS-2:0], 1'b0};
			end
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		// interpolation, one coordinate per multiply/add pair
		if (state_q == ST_MUL) begin
			prod_q <= prod_d;
		end
		if (state_q == ST_ADD) begin
			res_q[coord_q] <= sum_d[C-1:0];
			if (coord_q != COORD_LAST) begin
				coord_q <= coord_q + 1'b1;
			end
		end
	end

	assign m_axis_tdata  = DATA_BITS'({out_q[2], out_q[1], out_q[0]});
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tlast  = m_tlast_q;
	assign m_axis_tuser  = m_tuser_q;

`include "axis_plane_polygon_clipper_top_macros.svh"

	// a strict crossing keeps the partial remainder below the divisor
	`APC_ASSERT_NOW(a_div_rem, (state_q == ST_DIV), (rem_q < den_q), "divider remainder overflow")
	// closing a polygon drops the held vertex and rearms for a first vertex
	`APC_ASSERT_NEXT(a_close, (state_q == ST_FLUSH) && last_q && out_free, !pend_valid_q && !started_q, "polygon end left state behind")
	// an empty marker always ends its polygon
	`APC_ASSERT_NOW(a_marker, m_axis_tvalid && !m_axis_tuser, m_axis_tlast, "marker without end flag")
	// a crossing is pushed only after all three coordinates are done
	`APC_ASSERT_NOW(a_coord, (state_q == ST_PUSH_X), (coord_q == COORD_LAST), "crossing pushed early")

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import apc_pkg::*;

	localparam int CB = 24;
	localparam int DW = ((3*CB+7)/8)*8;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES = 400;

	// codes the package does not name
	localparam logic [1:0] AXIS_Z      = 2'd2;
	localparam logic [1:0] AXIS_Z_ALT  = 2'd3;	// decodes as z
	localparam logic [1:0] MODE_SPLIT  = 2'd2;
	localparam logic [1:0] MODE_SPLIT_ALT = 2'd3;	// decodes as split

	// receiver stall styles
	localparam int RX_STEADY  = 0;
	localparam int RX_RANDOM  = 1;
	localparam int RX_PATTERN = 2;

	localparam logic [CB-1:0] C_MIN = 24'h800000;
	localparam logic [CB-1:0] C_MAX = 24'h7FFFFF;

	typedef longint trio_t [3];

	typedef struct {
		logic [CB-1:0] x, y, z;
		logic          last;
	} vertex_req_t;

	typedef struct {
		logic [CB-1:0] x, y, z;
		logic          valid, last;
	} clip_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic [DW-1:0] s_axis_tdata = '0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	logic          s_axis_tlast = 1'b0;
	logic [DW-1:0] m_axis_tdata;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic          m_axis_tlast;
	logic          m_axis_tuser;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	axis_plane_polygon_clipper_top #(.COORD_BITS(CB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready), .s_axis_tlast(s_axis_tlast),
		.m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// -------------------------------------------------------------------
	// Clipper prediction: register copy plus polygon state
	// -------------------------------------------------------------------
	logic [1:0] axis_reg = AXIS_X;
	logic [1:0] mode_reg = MODE_ABOVE;
	longint     plane_reg = 0;
	trio_t      first_v = '{0, 0, 0};
	trio_t      prev_v = '{0, 0, 0};
	trio_t      held_v = '{0, 0, 0};
	bit         poly_open = 1'b0;
	bit         held_ok = 1'b0;	// newest vertex kept back until end is known

	vertex_req_t pending_vertices[$];
	clip_out_t   clip_results[$];
	int          mismatches = 0;
	int          results_seen = 0;

	function automatic int axis_index();
		if (axis_reg == AXIS_X) return 0;
		if (axis_reg == AXIS_Y) return 1;
		return 2;
	endfunction

	function automatic bit keeps(input longint c);
		if (mode_reg == MODE_ABOVE) return c >= plane_reg;
		if (mode_reg == MODE_BELOW) return c <= plane_reg;
		return 1'b1;
	endfunction

	function automatic bit crosses(input longint a, input longint b);
		return (a < plane_reg && b > plane_reg) || (a > plane_reg && b < plane_reg);
	endfunction

	// p + (q - p)*t, t unsigned Q0.16 truncated, products floored
	function automatic void crossing(input trio_t p, input trio_t q, output trio_t r);
		longint num, den, un, ud, t;
		int ax;
		ax = axis_index();
		num = p[ax] - plane_reg;
		den = p[ax] - q[ax];
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		t = (ud != 0) ? (un << T_BITS) / ud : 0;
		if (t > 65535) t = 65535;
		for (int k = 0; k < 3; k++)
			r[k] = p[k] + (((q[k] - p[k]) * t) >>> T_BITS);
	endfunction

	function automatic void push_result(input trio_t v, input bit valid, input bit last);
		clip_out_t o;
		o.x = 24'(v[0]);
		o.y = 24'(v[1]);
		o.z = 24'(v[2]);
		o.valid = valid;
		o.last = last;
		clip_results.push_back(o);
	endfunction

	function automatic void predict_clip(input vertex_req_t v);
		trio_t cur, cut, none;
		trio_t seq [4];
		int n, ax;
		n = 0;
		ax = axis_index();
		none = '{0, 0, 0};
		cur[0] = longint'($signed(v.x));
		cur[1] = longint'($signed(v.y));
		cur[2] = longint'($signed(v.z));
		if (held_ok) begin
			seq[n] = held_v;
			n++;
		end
		if (!poly_open) begin
			first_v = cur;
			prev_v = cur;
			poly_open = 1'b1;
		end else if (crosses(prev_v[ax], cur[ax])) begin
			crossing(prev_v, cur, cut);
			seq[n] = cut;
			n++;
		end
		if (keeps(cur[ax])) begin
			seq[n] = cur;
			n++;
		end
		// closing edge back to the first vertex
		if (v.last && crosses(cur[ax], first_v[ax])) begin
			crossing(cur, first_v, cut);
			seq[n] = cut;
			n++;
		end
		prev_v = cur;
		if (!v.last) begin
			held_ok = (n != 0);
			if (n != 0) begin
				for (int j = 0; j < n - 1; j++) push_result(seq[j], 1'b1, 1'b0);
				held_v = seq[n-1];
			end
		end else begin
			poly_open = 1'b0;
			held_ok = 1'b0;
			if (n == 0) push_result(none, 1'b0, 1'b1);	// fully clipped marker
			else for (int j = 0; j < n; j++) push_result(seq[j], 1'b1, j == n - 1);
		end
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %0s", $realtime, msg);
		mismatches++;
	endtask

	// -------------------------------------------------------------------
	// Sender: bursts of requests with random gaps
	// -------------------------------------------------------------------
	bit tx_gappy = 1'b0;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		bit offer;
		vertex_req_t nv;
		offer = 1'b0;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_clip(pending_vertices.pop_front());
			if (s_axis_tvalid && !s_axis_tready) begin
				offer = 1'b1;	// request must hold until taken
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (pending_vertices.size() != 0) begin
				offer = 1'b1;
				if (burst_left == 0) burst_left = $urandom_range(1, 12);
				burst_left--;
				if (burst_left == 0 && tx_gappy)
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 24)
					                                       : $urandom_range(0, 3);
			end
			s_axis_tvalid <= offer;
			if (offer) begin
				nv = pending_vertices[0];
				s_axis_tdata <= {nv.z, nv.y, nv.x};
				s_axis_tlast <= nv.last;
			end
		end
	end

	// -------------------------------------------------------------------
	// Receiver: own stall pattern plus a long hold-off on request
	// -------------------------------------------------------------------
	int rx_style = RX_STEADY;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;
	int rx_tick = 0;

	always @(posedge clk) begin
		rx_tick++;
		if (holds_served != holds_asked) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_style)
				RX_STEADY: m_axis_tready <= 1'b1;
				RX_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
				default:   m_axis_tready <= ((rx_tick % 7) < 4);
			endcase
		end
	end

	// -------------------------------------------------------------------
	// Monitor: each accepted result against the oldest prediction
	// -------------------------------------------------------------------
	always @(posedge clk) begin
		clip_out_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.x = m_axis_tdata[CB-1:0];
			got.y = m_axis_tdata[2*CB-1:CB];
			got.z = m_axis_tdata[3*CB-1:2*CB];
			got.valid = m_axis_tuser;
			got.last = m_axis_tlast;
			if (clip_results.size() == 0) begin
				flag_mismatch($sformatf("result %0d unexpected: %h %h %h v%b l%b",
					results_seen, got.x, got.y, got.z, got.valid, got.last));
			end else begin
				want = clip_results.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
				    got.valid !== want.valid || got.last !== want.last)
					flag_mismatch($sformatf(
						"result %0d got %h %h %h v%b l%b, want %h %h %h v%b l%b",
						results_seen, got.x, got.y, got.z, got.valid, got.last,
						want.x, want.y, want.z, want.valid, want.last));
			end
			results_seen++;
		end
	end

	// -------------------------------------------------------------------
	// Stimulus
	// -------------------------------------------------------------------
	task automatic queue_vertex(input logic [CB-1:0] x, y, z, input logic last);
		vertex_req_t v;
		v.x = x;
		v.y = y;
		v.z = z;
		v.last = last;
		pending_vertices.push_back(v);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
	                         input logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CLIP_AXIS:   axis_reg = val[1:0];
			REG_PLANE_VALUE: plane_reg = longint'($signed(val[23:0]));
			REG_CLIP_MODE:   mode_reg = val[1:0];
			default: ;
		endcase
	endtask

	// everything sent and answered, then let the sequencer drain
	task automatic settle();
		do @(posedge clk);
		while (pending_vertices.size() != 0 || s_axis_tvalid || clip_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CB-1:0] near_coord(input longint center, input int spread);
		longint v;
		v = center + longint'($urandom_range(0, 2 * spread)) - spread;
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return 24'(v);
	endfunction

	function automatic logic [CB-1:0] pick_coord(input bit noisy);
		int sel;
		sel = noisy ? 0 : $urandom_range(0, 9);
		if (sel == 0) return 24'($urandom);
		if (sel <= 4) return near_coord(plane_reg, 300);
		if (sel <= 8) return near_coord(plane_reg, 40000);
		return 24'(plane_reg);	// on the plane
	endfunction

	initial begin
		int sent, len;
		bit noisy;
		logic [CB-1:0] pv;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: x axis, plane 0, keep above
		rx_style = RX_RANDOM;
		tx_gappy = 1'b1;
		queue_vertex(24'hFFFF00, 24'h000000, 24'h000000, 1'b0);	// triangle across x = 0
		queue_vertex(24'h000200, 24'h000100, 24'h000000, 1'b0);
		queue_vertex(24'h000100, 24'hFFFE00, 24'h000400, 1'b1);
		queue_vertex(24'h000064, 24'h000001, 24'h000002, 1'b1);	// lone vertex, kept
		queue_vertex(24'hFFFFFF, 24'h000001, 24'h000002, 1'b1);	// lone vertex, clipped
		queue_vertex(C_MIN, C_MAX, C_MIN, 1'b0);			// all clipped: marker
		queue_vertex(24'hFFFFFB, 24'h000000, C_MAX, 1'b1);
		settle();

		// y axis, plane at the bottom extreme, keep below
		write_reg(REG_CLIP_AXIS, CFG_DATA_BITS'(AXIS_Y));
		write_reg(REG_PLANE_VALUE, CFG_DATA_BITS'(C_MIN));
		write_reg(REG_CLIP_MODE, CFG_DATA_BITS'(MODE_BELOW));
		queue_vertex(C_MAX, C_MIN, 24'h000001, 1'b0);
		queue_vertex(24'h000000, C_MAX, 24'hFFFFFF, 1'b1);
		settle();

		// axis code three acts as z; split; every edge crosses, closing one too
		rx_style = RX_PATTERN;
		write_reg(REG_CLIP_AXIS, CFG_DATA_BITS'(AXIS_Z_ALT));
		write_reg(REG_PLANE_VALUE, 24'h000400);
		write_reg(REG_CLIP_MODE, CFG_DATA_BITS'(MODE_SPLIT));
		queue_vertex(24'h000000, 24'h000000, 24'h000800, 1'b0);
		queue_vertex(24'h000100, 24'h000000, 24'h000000, 1'b0);
		queue_vertex(24'h000100, 24'h000100, 24'h000800, 1'b0);
		queue_vertex(24'h000000, 24'h000100, 24'h000000, 1'b1);
		settle();

		// settings changed in the middle of a polygon
		write_reg(REG_CLIP_AXIS, CFG_DATA_BITS'(AXIS_Z));
		write_reg(REG_PLANE_VALUE, 24'h000000);
		write_reg(REG_CLIP_MODE, CFG_DATA_BITS'(MODE_ABOVE));
		queue_vertex(24'h000001, 24'h000002, 24'hFFFED4, 1'b0);
		queue_vertex(24'h000005, 24'h000006, 24'h0002BC, 1'b0);
		settle();
		write_reg(REG_CLIP_MODE, CFG_DATA_BITS'(MODE_BELOW));
		write_reg(REG_PLANE_VALUE, 24'h000100);
		queue_vertex(24'h000009, 24'h000009, 24'hFFFFCE, 1'b1);
		settle();

		// full-scale edges, mode code three acts as split
		rx_style = RX_STEADY;
		tx_gappy = 1'b0;
		write_reg(REG_CLIP_AXIS, CFG_DATA_BITS'(AXIS_X));
		write_reg(REG_PLANE_VALUE, 24'h000000);
		write_reg(REG_CLIP_MODE, CFG_DATA_BITS'(MODE_SPLIT_ALT));
		queue_vertex(C_MIN, C_MAX, C_MIN, 1'b0);
		queue_vertex(C_MAX, C_MIN, C_MAX, 1'b0);
		queue_vertex(24'h000100, 24'hFFFF00, 24'h123456, 1'b1);
		settle();

		// random phases: mostly polygons around the plane, some noise
		for (int ph = 0; ph < 6; ph++) begin
			case ($urandom_range(0, 4))
				0: pv = C_MIN;
				1: pv = C_MAX;
				2: pv = '0;
				3: pv = near_coord(0, 3000);
				default: pv = 24'($urandom);
			endcase
			write_reg(REG_PLANE_VALUE, CFG_DATA_BITS'(pv));
			write_reg(REG_CLIP_AXIS, CFG_DATA_BITS'($urandom_range(0, 3)));
			write_reg(REG_CLIP_MODE, CFG_DATA_BITS'($urandom_range(0, 3)));
			rx_style = (ph % 3 == 0) ? RX_STEADY : (ph % 3 == 1) ? RX_RANDOM : RX_PATTERN;
			tx_gappy = (ph != 0 && ph != 3);
			// block fills up behind a stalled receiver while requests keep coming
			if (ph == 1) holds_asked++;
			sent = 0;
			while (sent < 30) begin
				noisy = ($urandom_range(0, 4) == 0);
				len = noisy ? $urandom_range(1, 2) : $urandom_range(3, 6);
				for (int i = 0; i < len; i++)
					queue_vertex(pick_coord(noisy), pick_coord(noisy), pick_coord(noisy),
					             i == len - 1);
				sent += len;
			end
			settle();
		end

		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/apc_pkg.sv
rtl/axis_plane_polygon_clipper_top.sv
verif/testbench.sv
